[src/efcs_pkg.sv]
`default_nettype none

package efcs_pkg;

	// frame and result field widths
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned RAW_ANGLE_W  = 21;
	localparam int unsigned STATUS_W     = 3;
	localparam int unsigned DELTA_W      = 22;
	localparam int unsigned SPEED_W      = 32;
	localparam int unsigned GAIN_W       = 32;
	localparam int unsigned SPEED_SHIFT  = 16;

	// default resolution of the stored angle
	localparam int unsigned ANGLE_BITS_DEF = 21;

	// stream widths, padded to whole bytes
	localparam int unsigned IN_DATA_W  = 4 * BYTE_W;
	localparam int unsigned OUT_USED_W = RAW_ANGLE_W + STATUS_W + 1 + DELTA_W + SPEED_W;
	localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// crc-8, polynomial x^8+x^2+x+1, msb first
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

	function automatic logic [BYTE_W-1:0] crc8_byte(
		input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data
	);
		logic [BYTE_W-1:0] v;
		v = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (v[BYTE_W-1]) begin
				v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[BYTE_W-2:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[src/encoder_frame_check_and_speed.sv]
`default_nettype none

// Encoder frame check and speed.
// Input stream s_*: one item is one received encoder frame of four bytes.
// Output stream m_*: one result item per input item, in order: the unpacked
// angle and status, the crc verdict, the wrapped angle change since the last
// good frame and the speed in rpm (Q8), saturated to 32 bits. A frame that
// fails the crc gives zero delta and zero speed and leaves the stored angle.
// Configuration: cfg_wr_en/cfg_wr_data load the 32-bit Q24 speed gain; write
// it only while no item is in flight.
// Pipeline: an item passes through the input register, the crc/wrap stage,
// the multiply stage and the output register, in that order.
// Throughput: one item per cycle unless the output stalls; the stored
// angle is updated in the crc/wrap stage, so a frame sees the last good angle.
// The 22x33 multiply has a stage of its own, saturation sits before the
// output register.
// Stall: each stage holds while the one after it is full and stalled, so
// up to four items are taken while the receiver holds m_tready low.
// Reset: all stages empty, stored angle and speed gain are zero.
module encoder_frame_check_and_speed #(
	parameter int unsigned ANGLE_BITS = efcs_pkg::ANGLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// config
	input  wire logic                              cfg_wr_en,
	input  wire logic [efcs_pkg::GAIN_W-1:0]       cfg_wr_data,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [7:0] angle_high_byte, [15:8] angle_mid_byte,
	// [23:16] angle_low_status_byte, [31:24] check_byte
	input  wire logic [efcs_pkg::IN_DATA_W-1:0]    s_tdata,
	// output stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [20:0] angle, [23:21] status_bits, [24] crc_ok,
	// [46:25] angle_delta, [78:47] speed_q8, [79] zero
	output logic [efcs_pkg::OUT_DATA_W-1:0]        m_tdata
);
	import efcs_pkg::*;

	localparam int unsigned AB   = ANGLE_BITS;
	localparam int unsigned DW   = AB + 1;
	localparam int unsigned PW   = DW + GAIN_W + 1;
	localparam int unsigned WIDE = 64;

	localparam logic signed [DW-1:0] HALF_POS = {2'b01, {(AB-1){1'b0}}};
	localparam logic signed [DW-1:0] HALF_NEG = {2'b11, {(AB-1){1'b0}}};
	localparam logic [DW-1:0]        FULL     = {1'b1, {AB{1'b0}}};
	localparam logic signed [WIDE-1:0] SAT_MAX = WIDE'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [WIDE-1:0] SAT_MIN = WIDE'(-64'sh0000_0000_8000_0000);

	// speed gain register
	logic [GAIN_W-1:0] speed_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_gain_q <= '0;
		end else if (cfg_wr_en) begin
			speed_gain_q <= cfg_wr_data;
		end
	end

	// stage valids and flow control
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;

	assign rdy_out  = !out_valid_q || m_tready;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1        <= s_tvalid;
			if (rdy_s2)  v_s2        <= v_s1;
			if (rdy_s3)  v_s3        <= v_s2;
			if (rdy_out) out_valid_q <= v_s3;
		end
	end

	// input register
	logic [IN_DATA_W-1:0] frame_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			frame_s1 <= s_tdata;
		end
	end

	// unpack, crc check and angle wrap
	logic [BYTE_W-1:0]                b0, b1, b2, chk;
	logic [RAW_ANGLE_W-1:0]           raw_angle;
	logic [RAW_ANGLE_W+AB-1:0]        raw_ext;
	logic [AB-1:0]                    angle_c;
	logic [BYTE_W-1:0]                crc_c;
	logic                             ok_c;
	logic signed [DW-1:0]             diff_c, wrap_c;
	logic [AB-1:0]                    last_angle_q;

	assign b0  = frame_s1[BYTE_W-1:0];
	assign b1  = frame_s1[2*BYTE_W-1:BYTE_W];
	assign b2  = frame_s1[3*BYTE_W-1:2*BYTE_W];
	assign chk = frame_s1[4*BYTE_W-1:3*BYTE_W];

	assign raw_angle = {b0, b1, b2[BYTE_W-1:STATUS_W]};
	assign raw_ext   = {{AB{1'b0}}, raw_angle};
	assign angle_c   = raw_ext[AB-1:0];

	assign crc_c = crc8_byte(crc8_byte(crc8_byte(CRC_INIT, b0), b1), b2);
	assign ok_c  = (crc_c == chk);

	always_comb begin
		diff_c = $signed({1'b0, angle_c}) - $signed({1'b0, last_angle_q});
		if (diff_c > HALF_POS) begin
			wrap_c = diff_c - $signed(FULL);
		end else if (diff_c < HALF_NEG) begin
			wrap_c = diff_c + $signed(FULL);
		end else begin
			wrap_c = diff_c;
		end
	end

	// stored angle follows good frames only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_angle_q <= '0;
		end else if (rdy_s2 && v_s1 && ok_c) begin
			last_angle_q <= angle_c;
		end
	end

	logic [AB-1:0]          angle_s2;
	logic [STATUS_W-1:0]    status_s2;
	logic                   ok_s2;
	logic signed [DW-1:0]   delta_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			angle_s2  <= angle_c;
			status_s2 <= b2[STATUS_W-1:0];
			ok_s2     <= ok_c;
			delta_s2  <= ok_c ? wrap_c : '0;
		end
	end

	// speed product
	logic signed [PW-1:0]   prod_c;
	logic signed [PW-1:0]   prod_s3;
	logic [AB-1:0]          angle_s3;
	logic [STATUS_W-1:0]    status_s3;
	logic                   ok_s3;
	logic signed [DW-1:0]   delta_s3;

	assign prod_c = delta_s2 * $signed({1'b0, speed_gain_q});

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			prod_s3   <= prod_c;
			angle_s3  <= angle_s2;
			status_s3 <= status_s2;
			ok_s3     <= ok_s2;
			delta_s3  <= delta_s2;
		end
	end

	// shift to Q8 and saturate
	logic signed [WIDE-1:0]       prod_wide, q_wide;
	logic [SPEED_W-1:0]           speed_c;
	logic [DW+DELTA_W-1:0]        delta_ext;
	logic [AB+RAW_ANGLE_W-1:0]    angle_ext;

	assign prod_wide = {{(WIDE-PW){prod_s3[PW-1]}}, prod_s3};
	assign q_wide    = prod_wide >>> SPEED_SHIFT;

	always_comb begin
		if (q_wide > SAT_MAX) begin
			speed_c = SAT_MAX[SPEED_W-1:0];
		end else if (q_wide < SAT_MIN) begin
			speed_c = SAT_MIN[SPEED_W-1:0];
		end else begin
			speed_c = q_wide[SPEED_W-1:0];
		end
	end

	assign delta_ext = {{DELTA_W{delta_s3[DW-1]}}, delta_s3};
	assign angle_ext = {{RAW_ANGLE_W{1'b0}}, angle_s3};

	// output register
	logic [RAW_ANGLE_W-1:0] angle_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   crc_ok_q;
	logic [DELTA_W-1:0]     delta_q;
	logic [SPEED_W-1:0]     speed_q;

	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			angle_q  <= angle_ext[RAW_ANGLE_W-1:0];
			status_q <= status_s3;
			crc_ok_q <= ok_s3;
			delta_q  <= delta_ext[DELTA_W-1:0];
			speed_q  <= speed_c;
		end
	end

	assign m_tdata = {{(OUT_DATA_W-OUT_USED_W){1'b0}},
		speed_q, delta_q, crc_ok_q, status_q, angle_q};

`ifndef SYNTH
	// a failed frame never carries a delta
	a_bad_crc_zero_delta: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !ok_s2 |-> delta_s2 == '0)
		else $error("nonzero delta on crc failure");

	// stored angle holds unless a good frame moves into the wrap stage
	a_last_angle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(rdy_s2 && v_s1 && ok_c) |=> $stable(last_angle_q))
		else $error("stored angle changed without a good frame");

	// wrapped delta stays within half a turn
	a_delta_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (delta_s2 <= HALF_POS) && (delta_s2 >= HALF_NEG))
		else $error("wrapped delta out of range");

	// a failed frame reports zero speed
	a_bad_crc_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !crc_ok_q |-> speed_q == '0)
		else $error("nonzero speed on crc failure");
`endif

endmodule

`default_nettype wire
